// ===== rtl/tdpb_pkg.sv =====
// ----------------------------------------------------------------------------
// tdpb_pkg
// Shared widths, constants and types of the tail-drop packet buffer timing block.
// ----------------------------------------------------------------------------
`default_nettype none

package tdpb_pkg;

    localparam int TIME_W = 48;
    localparam int SIZE_W = 9;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;
    localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};

    typedef logic [TIME_W-1:0] time_t;

    // control broadcast from the sequencer to every cell of the chain
    typedef struct packed {
        logic  shift;      // advance every cell toward the head by one place
        logic  push;       // store push_data into the selected cell
        time_t push_data;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/tdpb_cell.sv =====
// ----------------------------------------------------------------------------
// tdpb_cell
// One place of the finish-time chain: holds one finish time, takes its upper
// neighbor's value on a shift or a new value when selected for a push.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpb_cell
(
    input  wire                      clk,
    input  wire tdpb_pkg::cell_ctl_t ctl,
    input  wire                      push_sel,
    input  wire tdpb_pkg::time_t     up_data,
    output tdpb_pkg::time_t          data
);

    tdpb_pkg::time_t finish_reg;
    tdpb_pkg::time_t finish_next;

    always_comb
    begin
        finish_next = finish_reg;
        if (ctl.shift)
        begin
            finish_next = up_data;
        end
        else if (ctl.push && push_sel)
        begin
            finish_next = ctl.push_data;
        end
    end

    always_ff @(posedge clk)
    begin
        finish_reg <= finish_next;
    end

    assign data = finish_reg;

endmodule

`default_nettype wire

// ===== rtl/tail_drop_packet_buffer_timing.sv =====
// ----------------------------------------------------------------------------
// tail_drop_packet_buffer_timing
// Single-server packet timing with a bounded buffer and tail drop.
// ----------------------------------------------------------------------------
// Each request carries a packet's arrival time and processing time; the block
// answers with the time its processing starts, or a drop flag when the buffer
// already holds buffer_size packets (capped at DEPTH). Finish times of the
// buffered packets live in a chain of DEPTH cells, oldest at cell 0. A request
// first retires finished packets: the whole chain shifts one place per cycle
// while the head cell's finish time is at or before the arrival. It is then
// settled once the output register is free. Every packet is retired at most
// once. One request is worked on at a time; a new one is taken while the
// previous result still waits in the output register. The newest finish time
// is kept in its own register, so the start time never needs a read at a
// variable place of the chain. Finish times saturate at 2^48-1. Write
// buffer_size only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tail_drop_packet_buffer_timing
#(
    parameter int DEPTH = 256
)
(
    input  wire         clk,
    input  wire         rst_n,

    input  wire         cfg_we,
    input  wire  [8:0]  cfg_wdata,      // buffer_size

    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [95:0] s_axis_tdata,   // [47:0] arrival_time, [95:48] process_time

    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [47:0] start_time
    output logic        m_axis_tuser    // [0] dropped
);

    localparam int CW = $clog2(DEPTH + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                               state_reg, state_next;
    logic [CW-1:0]                      count_reg, count_next;
    logic [tdpb_pkg::SIZE_W-1:0]        size_reg;
    tdpb_pkg::time_t                    arrival_reg, arrival_next;
    tdpb_pkg::time_t                    proc_reg, proc_next;
    tdpb_pkg::time_t                    tail_reg, tail_next;
    logic                               m_valid_reg, m_valid_next;
    tdpb_pkg::time_t                    m_start_reg, m_start_next;
    logic                               m_drop_reg, m_drop_next;

    tdpb_pkg::cell_ctl_t                ctl;
    tdpb_pkg::time_t                    cell_data [DEPTH];
    logic [DEPTH-1:0]                   push_sel;

    logic                               in_accept;
    logic                               out_free;
    logic                               can_retire;
    logic                               decide;
    logic                               full;
    logic [31:0]                        cap;
    tdpb_pkg::time_t                    start_time;
    logic [tdpb_pkg::TIME_W:0]          sum;
    tdpb_pkg::time_t                    finish;

    // ---------------- chain of finish-time cells ----------------
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            // the cell at the current fill count takes a pushed packet
            assign push_sel[gi] = (count_reg == CW'(gi));

            if (gi == DEPTH - 1)
            begin : g_last
                tdpb_cell u_cell
                (
                    .clk      (clk),
                    .ctl      (ctl),
                    .push_sel (push_sel[gi]),
                    .up_data  (cell_data[gi]),
                    .data     (cell_data[gi])
                );
            end
            else
            begin : g_mid
                tdpb_cell u_cell
                (
                    .clk      (clk),
                    .ctl      (ctl),
                    .push_sel (push_sel[gi]),
                    .up_data  (cell_data[gi+1]),
                    .data     (cell_data[gi])
                );
            end
        end
    endgenerate

    // ---------------- sequencing ----------------
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // head packet finished by the arrival: retire it this cycle
    assign can_retire = (state_reg == ST_RUN) && (count_reg != '0) &&
                        (arrival_reg >= cell_data[0]);
    // nothing left to retire: settle the packet once the output can take it
    assign decide     = (state_reg == ST_RUN) && !can_retire && out_free;

    // effective capacity: buffer_size capped at the chain length
    assign cap  = (32'(size_reg) > 32'(DEPTH)) ? 32'(DEPTH) : 32'(size_reg);
    assign full = (32'(count_reg) >= cap);

    // start at arrival on an empty buffer, else behind the newest packet
    assign start_time = (count_reg == '0) ? arrival_reg : tail_reg;
    assign sum        = {1'b0, start_time} + {1'b0, proc_reg};
    assign finish     = sum[tdpb_pkg::TIME_W] ? tdpb_pkg::TIME_MAX
                                              : sum[tdpb_pkg::TIME_W-1:0];

    always_comb
    begin
        ctl.shift     = can_retire;
        ctl.push      = decide && !full;
        ctl.push_data = finish;
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        arrival_next = arrival_reg;
        proc_next    = proc_reg;
        tail_next    = tail_reg;
        m_valid_next = m_valid_reg;
        m_start_next = m_start_reg;
        m_drop_next  = m_drop_reg;

        // drain the output register when taken
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    arrival_next = s_axis_tdata[47:0];
                    proc_next    = s_axis_tdata[95:48];
                    state_next   = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (can_retire)
                begin
                    count_next = count_reg - CW'(1);
                end
                else if (decide)
                begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (full)
                    begin
                        // tail drop: report zero start, keep the buffer as is
                        m_start_next = '0;
                        m_drop_next  = 1'b1;
                    end
                    else
                    begin
                        m_start_next = start_time;
                        m_drop_next  = 1'b0;
                        tail_next    = finish;
                        count_next   = count_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            size_reg    <= tdpb_pkg::SIZE_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
            end
        end
    end

    // payload registers: no reset
    always_ff @(posedge clk)
    begin
        arrival_reg <= arrival_next;
        proc_reg    <= proc_next;
        tail_reg    <= tail_next;
        m_start_reg <= m_start_next;
        m_drop_reg  <= m_drop_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_start_reg;
    assign m_axis_tuser  = m_drop_reg;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(DEPTH))
        else $error("fill count beyond chain length");

    a_push_below_cap: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push |-> (32'(count_reg) < cap))
        else $error("push into a full buffer");

    a_drop_zero_start: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("dropped packet with nonzero start time");

    a_retire_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.shift |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("retire did not lower the fill count");

    a_no_shift_and_push: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.shift && ctl.push))
        else $error("shift and push in the same cycle");

endmodule

`default_nettype wire

// ===== bench/tail_drop_packet_buffer_timing_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tail_drop_packet_buffer_timing_tb
// Self-checking bench for the tail-drop packet buffer timing block.
// ----------------------------------------------------------------------------
// Drives packet requests (arrival, processing time) into the block and checks
// every start_time / dropped result against an in-bench scheduler that keeps
// its own ring of finish times. A short table of directed requests covers the
// corners (empty buffer, saturation, arrival going back in time, capacity 0,
// 1, 2, codes above the ring depth). Random phases follow, each starting from
// an empty buffer at a new capacity and time base, with light or heavy load
// so that the buffer both drains and fills up to the tail-drop point. Both
// stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tail_drop_packet_buffer_timing_tb;

    localparam int          RING_DEPTH  = 256;
    localparam int          CLK_HALF    = 4;
    localparam int          RESET_TICKS = 12;
    localparam int          SETTLE      = 8;        // cycles the block may still work
    localparam longint      CYCLE_LIMIT = 1_500_000;
    localparam int          N_DIRECTED  = 25;
    localparam int          N_PHASES    = 12;

    typedef enum logic { ROW_CONFIG, ROW_PACKET } row_kind_t;

    typedef struct packed {
        tdpb_pkg::time_t start_time;
        logic            dropped;
    } outcome_t;

    typedef struct packed {
        row_kind_t                   kind;
        logic [tdpb_pkg::SIZE_W-1:0] size;        // ROW_CONFIG only
        tdpb_pkg::time_t             arrival;
        tdpb_pkg::time_t             proc_time;
        logic                        fixed;       // expectation typed in below
        tdpb_pkg::time_t             exp_start;
        logic                        exp_dropped;
    } stim_row_t;

    // ------------------------------------------------------------------------
    // DUT signals, the driven ones known from time zero
    // ------------------------------------------------------------------------
    logic                        clk           = 1'b0;
    logic                        rst_n         = 1'b0;
    logic                        cfg_we        = 1'b0;
    logic [tdpb_pkg::SIZE_W-1:0] cfg_wdata     = '0;
    logic                        s_axis_tvalid = 1'b0;
    wire                         s_axis_tready;
    logic [95:0]                 s_axis_tdata  = '0;  // [47:0] arrival_time, [95:48] process_time
    wire                         m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    wire  [47:0]                 m_axis_tdata;        // [47:0] start_time
    wire                         m_axis_tuser;        // [0] dropped

    tail_drop_packet_buffer_timing #(
        .DEPTH (RING_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Scheduler state: finish times of buffered packets, oldest at ring_head
    // ------------------------------------------------------------------------
    tdpb_pkg::time_t             finish_ring [RING_DEPTH];
    logic [7:0]                  ring_head   = '0;
    logic [tdpb_pkg::SIZE_W-1:0] ring_count  = '0;
    logic [tdpb_pkg::SIZE_W-1:0] capacity    = tdpb_pkg::SIZE_RESET;

    outcome_t          predicted_outcomes [$];
    int                error_count = 0;
    longint            cycle_count = 0;
    bit                steady_flow = 1'b0;     // no idling on either side

    // Retire, pick the start time, then store or drop the new packet.
    function automatic outcome_t schedule_packet(input tdpb_pkg::time_t arrival,
                                                 input tdpb_pkg::time_t proc_time);
        logic [tdpb_pkg::SIZE_W-1:0] limit;
        logic [7:0]                  slot;
        tdpb_pkg::time_t             start;
        logic [tdpb_pkg::TIME_W:0]   sum;
        tdpb_pkg::time_t             finish;
        outcome_t                    res;
        limit = (int'(capacity) > RING_DEPTH) ? tdpb_pkg::SIZE_W'(RING_DEPTH) : capacity;
        // retire oldest first while finished by the arrival
        while (ring_count != 0 && arrival >= finish_ring[ring_head])
        begin
            ring_head  = ring_head + 8'd1;
            ring_count = ring_count - 9'd1;
        end
        if (ring_count == 0)
            start = arrival;
        else
        begin
            slot  = ring_head + ring_count[7:0] - 8'd1;
            start = finish_ring[slot];
        end
        sum    = {1'b0, start} + {1'b0, proc_time};
        finish = sum[tdpb_pkg::TIME_W] ? tdpb_pkg::TIME_MAX : sum[tdpb_pkg::TIME_W-1:0];
        if (ring_count >= limit)
        begin
            res.start_time = '0;
            res.dropped    = 1'b1;
        end
        else
        begin
            slot               = ring_head + ring_count[7:0];
            finish_ring[slot]  = finish;
            ring_count         = ring_count + 9'd1;
            res.start_time     = start;
            res.dropped        = 1'b0;
        end
        return res;
    endfunction

    // Mostly zero or short gaps, a few long; none in steady stretches.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady_flow || roll < 45)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic tdpb_pkg::time_t random_time();
        return tdpb_pkg::time_t'({$urandom, $urandom});
    endfunction

    // Offer one request, hold it until taken, then record its expectation.
    // tvalid stays high on return so back-to-back requests need no drop.
    task automatic send_packet(input tdpb_pkg::time_t arrival,
                               input tdpb_pkg::time_t proc_time,
                               input logic fixed, input outcome_t typed);
        int       gap;
        outcome_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {proc_time, arrival};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = schedule_packet(arrival, proc_time);
        predicted_outcomes.push_back(fixed ? typed : predicted);
    endtask

    // Drop tvalid, wait for every result, give the block time to go idle,
    // then write buffer_size.
    task automatic write_buffer_size(input logic [tdpb_pkg::SIZE_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (predicted_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        capacity  = value;
    endtask

    // ------------------------------------------------------------------------
    // Directed requests; expectations typed in where they are obvious
    // ------------------------------------------------------------------------
    stim_row_t directed_rows [N_DIRECTED];

    initial
    begin
        directed_rows = '{
            // empty buffer after reset: start at arrival
            '{ROW_PACKET, 9'd0, 48'd0, 48'd0, 1'b1, 48'd0, 1'b0},
            // zero-length packet retires at equal arrival
            '{ROW_PACKET, 9'd0, 48'd0, 48'd10, 1'b1, 48'd0, 1'b0},
            '{ROW_PACKET, 9'd0, 48'd5, 48'd10, 1'b0, 48'd0, 1'b0},
            // late arrival retires everything; finish saturates
            '{ROW_PACKET, 9'd0, tdpb_pkg::TIME_MAX - 48'd5, tdpb_pkg::TIME_MAX, 1'b1,
              tdpb_pkg::TIME_MAX - 48'd5, 1'b0},
            '{ROW_PACKET, 9'd0, tdpb_pkg::TIME_MAX - 48'd1, 48'd1, 1'b0, 48'd0, 1'b0},
            // arrival going back in time retires nothing
            '{ROW_PACKET, 9'd0, 48'd0, 48'd7, 1'b0, 48'd0, 1'b0},
            '{ROW_PACKET, 9'd0, tdpb_pkg::TIME_MAX, 48'd0, 1'b1, tdpb_pkg::TIME_MAX, 1'b0},
            // capacity zero drops everything and flushes the buffer
            '{ROW_CONFIG, 9'd0, 48'd0, 48'd0, 1'b0, 48'd0, 1'b0},
            '{ROW_PACKET, 9'd0, tdpb_pkg::TIME_MAX, tdpb_pkg::TIME_MAX, 1'b1, 48'd0, 1'b1},
            // capacity one
            '{ROW_CONFIG, 9'd1, 48'd0, 48'd0, 1'b0, 48'd0, 1'b0},
            '{ROW_PACKET, 9'd0, 48'd100, 48'd50, 1'b1, 48'd100, 1'b0},
            '{ROW_PACKET, 9'd0, 48'd120, 48'd5, 1'b1, 48'd0, 1'b1},
            '{ROW_PACKET, 9'd0, 48'd150, 48'd5, 1'b1, 48'd150, 1'b0},
            '{ROW_PACKET, 9'd0, 48'd155, 48'd0, 1'b1, 48'd155, 1'b0},
            '{ROW_PACKET, 9'd0, 48'd155, 48'd3, 1'b0, 48'd0, 1'b0},
            // capacity two fills, then tail drop
            '{ROW_CONFIG, 9'd2, 48'd0, 48'd0, 1'b0, 48'd0, 1'b0},
            '{ROW_PACKET, 9'd0, 48'd156, 48'd20, 1'b0, 48'd0, 1'b0},
            '{ROW_PACKET, 9'd0, 48'd156, 48'd1, 1'b1, 48'd0, 1'b1},
            // codes above the ring depth act as the full ring
            '{ROW_CONFIG, 9'd511, 48'd0, 48'd0, 1'b0, 48'd0, 1'b0},
            '{ROW_PACKET, 9'd0, 48'd160, 48'h8000_0000_0000, 1'b0, 48'd0, 1'b0},
            '{ROW_PACKET, 9'd0, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 1'b0, 48'd0, 1'b0},
            '{ROW_CONFIG, 9'd257, 48'd0, 48'd0, 1'b0, 48'd0, 1'b0},
            '{ROW_PACKET, 9'd0, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 1'b0, 48'd0, 1'b0},
            // flush before the random part
            '{ROW_CONFIG, 9'd0, 48'd0, 48'd0, 1'b0, 48'd0, 1'b0},
            '{ROW_PACKET, 9'd0, tdpb_pkg::TIME_MAX, 48'd0, 1'b1, 48'd0, 1'b1}
        };
    end

    // ------------------------------------------------------------------------
    // Stimulus: reset, directed table, random phases, drain, verdict
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned                 phase_sizes [N_PHASES];
        logic [tdpb_pkg::SIZE_W-1:0] size;
        int                          n_items;
        bit                          heavy;
        tdpb_pkg::time_t             now;
        tdpb_pkg::time_t             arrival;
        tdpb_pkg::time_t             proc_time;
        logic [tdpb_pkg::TIME_W:0]   advanced;
        outcome_t                    typed;

        phase_sizes = '{1, 256, 2, 511, 3, 0, 257, 8, 255, 64, 0, 0};
        phase_sizes[10] = $urandom_range(0, 511);
        phase_sizes[11] = $urandom_range(4, 40);

        repeat (RESET_TICKS) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CONFIG)
                write_buffer_size(directed_rows[i].size);
            else
            begin
                typed.start_time = directed_rows[i].exp_start;
                typed.dropped    = directed_rows[i].exp_dropped;
                send_packet(directed_rows[i].arrival, directed_rows[i].proc_time,
                            directed_rows[i].fixed, typed);
            end
        end

        typed = '0;
        for (int phase = 0; phase < N_PHASES; phase++)
        begin
            size        = tdpb_pkg::SIZE_W'(phase_sizes[phase]);
            heavy       = (phase % 3 != 2);
            steady_flow = (phase % 4 == 2);
            n_items     = (size >= 200) ? 260 : 110;

            // empty the buffer: capacity zero plus a last-possible arrival
            write_buffer_size('0);
            send_packet(tdpb_pkg::TIME_MAX, random_time(), 1'b0, typed);
            write_buffer_size(size);

            case ($urandom_range(0, 3))
                0:       now = '0;
                1:       now = tdpb_pkg::TIME_MAX - tdpb_pkg::time_t'($urandom_range(0, 3000));
                default: now = random_time();
            endcase

            repeat (n_items)
            begin
                // advance the clock of the traffic, saturating at the top
                advanced = {1'b0, now} + (tdpb_pkg::TIME_W + 1)'(heavy ? $urandom_range(0, 3)
                                                                       : $urandom_range(0, 24));
                now      = advanced[tdpb_pkg::TIME_W] ? tdpb_pkg::TIME_MAX
                                                      : advanced[tdpb_pkg::TIME_W-1:0];
                arrival  = now;
                // now and then an arrival going back in time
                if ($urandom_range(0, 29) == 0)
                    arrival = (now > 48'd50) ? now - tdpb_pkg::time_t'($urandom_range(0, 50))
                                             : '0;
                proc_time = tdpb_pkg::time_t'(heavy ? $urandom_range(2, 12)
                                                    : $urandom_range(0, 15));
                if ($urandom_range(0, 79) == 0)
                    proc_time = random_time();
                send_packet(arrival, proc_time, 1'b0, typed);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (predicted_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random backpressure with steady stretches
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int stall;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        outcome_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (predicted_outcomes.size() == 0)
            begin
                $error("unexpected result: start_time %h dropped %b",
                       m_axis_tdata, m_axis_tuser);
                error_count++;
            end
            else
            begin
                want = predicted_outcomes.pop_front();
                if (m_axis_tdata !== want.start_time)
                begin
                    $error("start_time: expected %h, got %h",
                           want.start_time, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tuser !== want.dropped)
                begin
                    $error("dropped: expected %b, got %b", want.dropped, m_axis_tuser);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/tdpb_pkg.sv
rtl/tdpb_cell.sv
rtl/tail_drop_packet_buffer_timing.sv
bench/tail_drop_packet_buffer_timing_tb.sv
